// File: src/aes_pkg.sv
// aes_pkg: shared types, constants and byte-level functions for the aes-128 block
// no dependencies
package aes_pkg;

  localparam int BlockW = 128;
  localparam int WordW = 64;
  localparam int NumRk = 11;
  localparam int RkWords = 2 * NumRk;
  localparam int RkAddrW = $clog2(RkWords);
  localparam int RoundW = 4;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 1'b1;

  localparam logic [7:0] Poly = 8'h1b;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_WR,
    ST_FETCH,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  // control from the controller to the round datapath
  typedef struct packed {
    logic dec;
    logic [RoundW-1:0] round;
  } ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? Poly : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] sbox_rev(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    sbox_rev = t[x];
  endfunction

  // byte i of a 128-bit block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int i);
    get_byte = s[BlockW-1-8*i -: 8];
  endfunction

  // one forward round without key addition; last skips mix columns
  function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
                                                   input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [BlockW-1:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4*c] = sbox(get_byte(s, r + 4*((c + r) % 4)));
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (!last) begin
        t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) o[BlockW-1-8*i -: 8] = t[i];
    enc_round = o;
  endfunction

  // inverse shift rows and inverse sub bytes
  function automatic logic [BlockW-1:0] dec_sub(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[BlockW-1-8*(r + 4*c) -: 8] = sbox_rev(get_byte(s, r + 4*((c - r + 4) % 4)));
    dec_sub = o;
  endfunction

  // inverse mix columns
  function automatic logic [BlockW-1:0] inv_mix(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c); a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
      o[BlockW-1-8*(4*c) -: 8] =
        gmul(a0, 8'h0e) ^ gmul(a1, 8'h0b) ^ gmul(a2, 8'h0d) ^ gmul(a3, 8'h09);
      o[BlockW-1-8*(4*c+1) -: 8] =
        gmul(a0, 8'h09) ^ gmul(a1, 8'h0e) ^ gmul(a2, 8'h0b) ^ gmul(a3, 8'h0d);
      o[BlockW-1-8*(4*c+2) -: 8] =
        gmul(a0, 8'h0d) ^ gmul(a1, 8'h09) ^ gmul(a2, 8'h0e) ^ gmul(a3, 8'h0b);
      o[BlockW-1-8*(4*c+3) -: 8] =
        gmul(a0, 8'h0b) ^ gmul(a1, 8'h0d) ^ gmul(a2, 8'h09) ^ gmul(a3, 8'h0e);
    end
    inv_mix = o;
  endfunction

  // next round key from the previous one
  function automatic logic [BlockW-1:0] next_rk(input logic [BlockW-1:0] k,
                                                 input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_rk = {w0, w1, w2, w3};
  endfunction

endpackage

// File: src/aes128_block_cipher_unit.sv
// aes128_block_cipher_unit: aes-128 ecb core, round keys kept in memory
// depends on aes_pkg, aes_keystore, aes_round
//
// usage: write key_high (index 0) and key_low (index 1) through wr_en/wr_idx/
// wr_data while the core is idle. raise start with cmd (0 encrypt, 1 decrypt)
// and block_high/block_low; the beat is taken when start is high and busy low.
// the first beat after a key write or reset first expands the key: each round
// key comes from a feedback register and is written to the key memory in
// alternating write and compute states. every beat then runs from accept to
// done through a fetch state that reads the key memory, then the initial key
// add and ten rounds, each round reading its key from the registered-read
// key memory ahead of use. busy drops in the cycle after done, so a new beat
// is taken only once the previous one is done.
// done is high for one cycle with result_high/result_low; the receiver
// cannot stall, the result stays on the outputs until the next beat loads.
// reset clears the key registers to zero and marks expansion pending; the
// key memory itself is not cleared since it is always written before read.
module aes128_block_cipher_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [aes_pkg::CfgIdxW-1:0] wr_idx,
  input  logic [aes_pkg::WordW-1:0]  wr_data,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd,
  input  logic [aes_pkg::WordW-1:0]  block_high,
  input  logic [aes_pkg::WordW-1:0]  block_low,
  output logic                       done,
  output logic [aes_pkg::WordW-1:0]  result_high,
  output logic [aes_pkg::WordW-1:0]  result_low
);
  import aes_pkg::*;

  state_t state, state_next;
  logic [WordW-1:0] key_high, key_low;
  logic keys_ready;
  logic [BlockW-1:0] blk;
  logic [BlockW-1:0] ek;
  logic [7:0] rc;
  logic [RoundW-1:0] cnt;
  logic dec;
  ctl_t ctl;
  logic [3:0] raddr;
  logic [BlockW-1:0] rk;
  logic [BlockW-1:0] dout;
  logic kwe, load, step;

  // key registers and expansion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      keys_ready <= 1'b0;
    end else begin
      if (wr_en && wr_idx == RegKeyHigh) begin
        key_high <= wr_data;
        keys_ready <= 1'b0;
      end else if (wr_en && wr_idx == RegKeyLow) begin
        key_low <= wr_data;
        keys_ready <= 1'b0;
      end else if (state == ST_EXP_WR && cnt == RoundW'(NumRk - 1)) begin
        keys_ready <= 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = keys_ready ? ST_FETCH : ST_EXP_WR;
      ST_EXP_WR: state_next = (cnt == RoundW'(NumRk - 1)) ? ST_FETCH : ST_EXP_RD;
      ST_EXP_RD: state_next = ST_EXP_WR;
      ST_FETCH:  state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROUND;
      ST_ROUND:  if (cnt == RoundW'(NumRk - 1)) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    kwe = (state == ST_EXP_WR);
    load = (state == ST_LOAD);
    step = (state == ST_ROUND);
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
  end

  // round key read address: first key in the fetch cycle, then one ahead
  always_comb begin
    raddr = dec ? RoundW'(NumRk - 1) - cnt : cnt;
    if (state == ST_LOAD || (state == ST_ROUND && cnt != RoundW'(NumRk - 1)))
      raddr = dec ? RoundW'(NumRk - 2) - cnt : cnt + 4'd1;
  end

  assign ctl = '{dec: dec, round: (dec ? RoundW'(NumRk - 1) - cnt : cnt)};

  // control registers and expansion datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      dec <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (start) begin
            dec <= cmd;
            blk <= {block_high, block_low};
            ek <= {key_high, key_low};
            rc <= 8'h01;
          end
        end
        ST_EXP_WR: begin
          if (cnt == RoundW'(NumRk - 1)) cnt <= '0;
          else cnt <= cnt + 4'd1;
        end
        ST_EXP_RD: begin
          ek <= next_rk(ek, rc);
          rc <= xtime(rc);
        end
        ST_LOAD: cnt <= 4'd1;
        ST_ROUND: cnt <= cnt + 4'd1;
        default: cnt <= '0;
      endcase
    end
  end

  aes_keystore u_keys (
    .clk(clk), .we(kwe), .waddr(cnt), .wdata(ek), .raddr(raddr), .rdata(rk)
  );

  aes_round u_round (
    .clk(clk), .load(load), .step(step), .ctl(ctl), .din(blk), .rk(rk), .dout(dout)
  );

  assign result_high = dout[BlockW-1:WordW];
  assign result_low = dout[WordW-1:0];

  // a result only follows work
  a_done_after_round: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_ROUND)) else $error("done without final round");

  // rounds never run on a pending key
  a_ready_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> keys_ready) else $error("rounds with stale keys");

  // busy while processing
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule

// File: src/aes_ram.sv
// aes_ram: generic single-port write, single-port read ram with registered read
// no dependencies
module aes_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/aes_keystore.sv
// aes_keystore: round key memory, two rams holding the high and low key halves
// depends on aes_pkg and aes_ram
module aes_keystore (
  input  logic                         clk,
  input  logic                         we,
  input  logic [3:0]                   waddr,
  input  logic [aes_pkg::BlockW-1:0]   wdata,
  input  logic [3:0]                   raddr,
  output logic [aes_pkg::BlockW-1:0]   rdata
);
  import aes_pkg::*;

  // one entry per round key, halves in separate arrays
  aes_ram #(.Width(WordW), .Depth(NumRk)) u_hi (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata[BlockW-1:WordW]),
    .raddr(raddr), .rdata(rdata[BlockW-1:WordW])
  );
  aes_ram #(.Width(WordW), .Depth(NumRk)) u_lo (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata[WordW-1:0]),
    .raddr(raddr), .rdata(rdata[WordW-1:0])
  );
endmodule

// File: src/aes_round.sv
// aes_round: state register, one encrypt or decrypt round per step cycle
// depends on aes_pkg
module aes_round (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  aes_pkg::ctl_t              ctl,
  input  logic [aes_pkg::BlockW-1:0] din,
  input  logic [aes_pkg::BlockW-1:0] rk,
  output logic [aes_pkg::BlockW-1:0] dout
);
  import aes_pkg::*;

  logic [BlockW-1:0] st;
  logic [BlockW-1:0] st_next;
  logic [BlockW-1:0] dsub;
  logic last;

  assign last = (ctl.round == RoundW'(NumRk - 1)) || (ctl.round == RoundW'(0));
  assign dsub = dec_sub(st) ^ rk;

  // round function; decrypt applies inverse mix after key except last round
  always_comb begin
    if (load) st_next = din ^ rk;
    else if (!ctl.dec) st_next = enc_round(st, ctl.round == RoundW'(NumRk - 1)) ^ rk;
    else if (last) st_next = dsub;
    else st_next = inv_mix(dsub);
  end

  always_ff @(posedge clk) begin
    if (load || step) st <= st_next;
  end

  assign dout = st;
endmodule
